/* design/tgp_pkg.sv */
`timescale 1ns / 1ps

package tgp_pkg;

    localparam int MAX_CELLS = 32;
    localparam int ITEM_W    = 12;
    localparam int COUNT_W   = 6;
    localparam int INDEX_W   = 5;
    localparam int ID_W      = 8;
    localparam int NB_COUNT  = 8;
    localparam int QDEPTH    = 2;
    localparam int QAW       = 1;

    typedef enum logic [1:0] {
        CFG_AREA_WIDTH  = 2'd0,
        CFG_AREA_HEIGHT = 2'd1,
        CFG_ID_BASE     = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV_SHARE,
        BK_DIV_WIDTH,
        BK_DIV_HEIGHT,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic [ITEM_W-1:0]  total_items;
        logic [COUNT_W-1:0] cell_count;
    } t_in;

    typedef struct packed {
        logic [INDEX_W-1:0]       cell_index;
        logic [ITEM_W-1:0]        item_share;
        logic [ITEM_W-1:0]        left_edge;
        logic [ITEM_W-1:0]        top_edge;
        logic [ITEM_W-1:0]        right_edge;
        logic [ITEM_W-1:0]        bottom_edge;
        logic [NB_COUNT*ID_W-1:0] neighbour_ids;
        logic [3:0]               distinct_neighbours;
        logic [COUNT_W-1:0]       grid_cols;
        logic [COUNT_W-1:0]       grid_rows;
        logic                     last;
        logic                     error;
    } t_out;

    typedef struct packed {
        logic [ITEM_W-1:0]  total_items;
        logic [COUNT_W-1:0] cell_count;
        logic [COUNT_W-1:0] grid_rows;
        logic [COUNT_W-1:0] grid_cols;
        logic               err;
    } t_job;

    typedef struct packed {
        logic [COUNT_W-1:0] rows;
        logic [COUNT_W-1:0] cols;
    } t_shape;

    typedef struct packed {
        logic               start;
        logic [ITEM_W-1:0]  dividend;
        logic [COUNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [ITEM_W-1:0]  quotient;
        logic [COUNT_W-1:0] remainder;
    } t_div_rsp;

    // Factor pair of n with the smallest difference, rows <= cols.
    function automatic t_shape f_grid_shape(input logic [COUNT_W-1:0] n);
        t_shape s;
        s.rows = 6'd1;
        s.cols = n;
        case (n)
            6'd4:    begin s.rows = 6'd2; s.cols = 6'd2;  end
            6'd6:    begin s.rows = 6'd2; s.cols = 6'd3;  end
            6'd8:    begin s.rows = 6'd2; s.cols = 6'd4;  end
            6'd9:    begin s.rows = 6'd3; s.cols = 6'd3;  end
            6'd10:   begin s.rows = 6'd2; s.cols = 6'd5;  end
            6'd12:   begin s.rows = 6'd3; s.cols = 6'd4;  end
            6'd14:   begin s.rows = 6'd2; s.cols = 6'd7;  end
            6'd15:   begin s.rows = 6'd3; s.cols = 6'd5;  end
            6'd16:   begin s.rows = 6'd4; s.cols = 6'd4;  end
            6'd18:   begin s.rows = 6'd3; s.cols = 6'd6;  end
            6'd20:   begin s.rows = 6'd4; s.cols = 6'd5;  end
            6'd21:   begin s.rows = 6'd3; s.cols = 6'd7;  end
            6'd22:   begin s.rows = 6'd2; s.cols = 6'd11; end
            6'd24:   begin s.rows = 6'd4; s.cols = 6'd6;  end
            6'd25:   begin s.rows = 6'd5; s.cols = 6'd5;  end
            6'd26:   begin s.rows = 6'd2; s.cols = 6'd13; end
            6'd27:   begin s.rows = 6'd3; s.cols = 6'd9;  end
            6'd28:   begin s.rows = 6'd4; s.cols = 6'd7;  end
            6'd30:   begin s.rows = 6'd5; s.cols = 6'd6;  end
            6'd32:   begin s.rows = 6'd4; s.cols = 6'd8;  end
            default: begin s.rows = 6'd1; s.cols = n;     end
        endcase
        return s;
    endfunction

endpackage

/* design/tgp_front.sv */
`timescale 1ns / 1ps

module tgp_front (
    input  tgp_pkg::t_in  i_data,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_full,
    output logic          o_push,
    output tgp_pkg::t_job o_job
);
    import tgp_pkg::*;

    logic [COUNT_W-1:0] w_n;
    t_shape             w_shape;

    assign w_n     = (i_data.cell_count > COUNT_W'(MAX_CELLS)) ? COUNT_W'(MAX_CELLS)
                                                               : i_data.cell_count;
    assign w_shape = f_grid_shape(w_n);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_job.total_items = i_data.total_items;
        o_job.cell_count  = w_n;
        o_job.grid_rows   = w_shape.rows;
        o_job.grid_cols   = w_shape.cols;
        o_job.err         = (i_data.cell_count == '0);
    end

endmodule

/* design/tgp_fifo.sv */
`timescale 1ns / 1ps

module tgp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tgp_pkg::t_job i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output tgp_pkg::t_job o_data,
    output logic          o_empty
);
    import tgp_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* design/tgp_div.sv */
`timescale 1ns / 1ps

module tgp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tgp_pkg::t_div_req i_req,
    output tgp_pkg::t_div_rsp o_rsp
);
    import tgp_pkg::*;

    logic [ITEM_W-1:0]  r_quo;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_div;
    logic [3:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [COUNT_W:0]   w_trial;
    logic [COUNT_W+1:0] w_diff;
    logic               w_ge;

    assign w_trial = {r_rem, r_quo[ITEM_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_div};
    assign w_ge    = !w_diff[COUNT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'(ITEM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ITEM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[COUNT_W-1:0] : w_trial[COUNT_W-1:0];
        end
    end

    always_comb begin
        o_rsp.done      = r_done;
        o_rsp.quotient  = r_quo;
        o_rsp.remainder = r_rem;
    end

endmodule

/* design/tgp_back.sv */
`timescale 1ns / 1ps

module tgp_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tgp_pkg::t_job              i_job,
    input  logic                       i_job_empty,
    output logic                       o_job_pop,
    input  logic [tgp_pkg::ITEM_W-1:0] i_area_width,
    input  logic [tgp_pkg::ITEM_W-1:0] i_area_height,
    input  logic [tgp_pkg::ID_W-1:0]   i_id_base,
    output tgp_pkg::t_out              o_data,
    output logic                       o_valid,
    input  logic                       i_ready
);
    import tgp_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic [COUNT_W-1:0] r_n;
    logic [COUNT_W-1:0] r_rows;
    logic [COUNT_W-1:0] r_cols;
    logic [ITEM_W-1:0]  r_share;
    logic [COUNT_W-1:0] r_share_rem;
    logic [ITEM_W-1:0]  r_pw;
    logic [COUNT_W-1:0] r_wrem;
    logic [ITEM_W-1:0]  r_ph;
    logic [COUNT_W-1:0] r_hrem;
    logic [INDEX_W-1:0] r_idx;
    logic [INDEX_W-1:0] r_x;
    logic [INDEX_W-1:0] r_y;
    logic [COUNT_W-1:0] r_rowbase;
    logic [ITEM_W-1:0]  r_left;
    logic [ITEM_W-1:0]  r_top;
    t_out               r_out;
    logic               r_out_valid;

    logic w_out_free;
    logic w_load_err;
    logic w_load_cell;
    logic w_start_job;

    logic [COUNT_W-1:0] w_x;
    logic [COUNT_W-1:0] w_xm;
    logic [COUNT_W-1:0] w_xp;
    logic [COUNT_W-1:0] w_ymb;
    logic [COUNT_W-1:0] w_ypb;
    logic               w_last_col;
    logic               w_last_row;
    logic               w_last_cell;
    logic [COUNT_W-1:0] w_nb_idx [NB_COUNT];
    logic [ID_W-1:0]    w_nb_id  [NB_COUNT];
    logic [ID_W-1:0]    w_self;
    logic [3:0]         w_distinct;
    t_out               w_cell;
    t_out               w_err_cell;

    tgp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_out_free = !r_out_valid || i_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (w_start_job) begin
                    n_state = BK_DIV_SHARE;
                end
            end
            BK_DIV_SHARE: begin
                if (w_div_rsp.done) begin
                    n_state = BK_DIV_WIDTH;
                end
            end
            BK_DIV_WIDTH: begin
                if (w_div_rsp.done) begin
                    n_state = BK_DIV_HEIGHT;
                end
            end
            BK_DIV_HEIGHT: begin
                if (w_div_rsp.done) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (w_load_cell && w_last_cell) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        w_start_job        = 1'b0;
        w_load_err         = 1'b0;
        w_load_cell        = 1'b0;
        o_job_pop          = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = i_job.total_items;
        w_div_req.divisor  = i_job.cell_count;
        case (r_state)
            BK_IDLE: begin
                if (!i_job_empty) begin
                    if (i_job.err) begin
                        w_load_err = w_out_free;
                        o_job_pop  = w_out_free;
                    end else begin
                        w_start_job     = 1'b1;
                        o_job_pop       = 1'b1;
                        w_div_req.start = 1'b1;
                    end
                end
            end
            BK_DIV_SHARE: begin
                w_div_req.dividend = i_area_width;
                w_div_req.divisor  = r_cols;
                w_div_req.start    = w_div_rsp.done;
            end
            BK_DIV_WIDTH: begin
                w_div_req.dividend = i_area_height;
                w_div_req.divisor  = r_rows;
                w_div_req.start    = w_div_rsp.done;
            end
            BK_DIV_HEIGHT: begin
            end
            BK_EMIT: begin
                w_load_cell = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // Geometry and torus neighbours of the current cell.
    always_comb begin
        w_x         = {1'b0, r_x};
        w_last_col  = (w_x == r_cols - 6'd1);
        w_last_row  = ({1'b0, r_y} == r_rows - 6'd1);
        w_last_cell = ({1'b0, r_idx} == r_n - 6'd1);
        w_xm        = (r_x == '0) ? r_cols - 6'd1 : w_x - 6'd1;
        w_xp        = w_last_col ? '0 : w_x + 6'd1;
        w_ymb       = (r_y == '0) ? r_n - r_cols : r_rowbase - r_cols;
        w_ypb       = w_last_row ? '0 : r_rowbase + r_cols;

        w_nb_idx[0] = w_ymb + w_xm;
        w_nb_idx[1] = w_ymb + w_x;
        w_nb_idx[2] = w_ymb + w_xp;
        w_nb_idx[3] = r_rowbase + w_xp;
        w_nb_idx[4] = w_ypb + w_xp;
        w_nb_idx[5] = w_ypb + w_x;
        w_nb_idx[6] = w_ypb + w_xm;
        w_nb_idx[7] = r_rowbase + w_xm;

        w_self = i_id_base + {3'b000, r_idx};
        for (int j = 0; j < NB_COUNT; j++) begin
            w_nb_id[j] = i_id_base + {2'b00, w_nb_idx[j]};
        end
    end

    always_comb begin
        logic seen;
        w_distinct = '0;
        for (int j = 0; j < NB_COUNT; j++) begin
            seen = 1'b0;
            for (int k = 0; k < j; k++) begin
                if (w_nb_id[k] == w_nb_id[j]) begin
                    seen = 1'b1;
                end
            end
            if (!seen && (w_nb_id[j] != w_self)) begin
                w_distinct = w_distinct + 4'd1;
            end
        end
    end

    always_comb begin
        w_cell.cell_index  = r_idx;
        w_cell.item_share  = w_last_cell ? r_share + {6'd0, r_share_rem} : r_share;
        w_cell.left_edge   = r_left;
        w_cell.top_edge    = r_top;
        w_cell.right_edge  = r_left + r_pw + (w_last_col ? {6'd0, r_wrem} : '0);
        w_cell.bottom_edge = r_top + r_ph + (w_last_row ? {6'd0, r_hrem} : '0);
        for (int j = 0; j < NB_COUNT; j++) begin
            w_cell.neighbour_ids[j*ID_W +: ID_W] = w_nb_id[j];
        end
        w_cell.distinct_neighbours = w_distinct;
        w_cell.grid_cols           = r_cols;
        w_cell.grid_rows           = r_rows;
        w_cell.last                = w_last_cell;
        w_cell.error               = 1'b0;
    end

    always_comb begin
        w_err_cell       = '0;
        w_err_cell.last  = 1'b1;
        w_err_cell.error = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_err || w_load_cell) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start_job) begin
            r_n     <= i_job.cell_count;
            r_rows  <= i_job.grid_rows;
            r_cols  <= i_job.grid_cols;
        end
        if (r_state == BK_DIV_SHARE && w_div_rsp.done) begin
            r_share     <= w_div_rsp.quotient;
            r_share_rem <= w_div_rsp.remainder;
        end
        if (r_state == BK_DIV_WIDTH && w_div_rsp.done) begin
            r_pw   <= w_div_rsp.quotient;
            r_wrem <= w_div_rsp.remainder;
        end
        if (r_state == BK_DIV_HEIGHT && w_div_rsp.done) begin
            r_ph      <= w_div_rsp.quotient;
            r_hrem    <= w_div_rsp.remainder;
            r_idx     <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_rowbase <= '0;
            r_left    <= '0;
            r_top     <= '0;
        end
        if (w_load_cell) begin
            r_idx <= r_idx + 1'b1;
            if (w_last_col) begin
                r_x       <= '0;
                r_left    <= '0;
                r_y       <= r_y + 1'b1;
                r_top     <= r_top + r_ph;
                r_rowbase <= r_rowbase + r_cols;
            end else begin
                r_x    <= r_x + 1'b1;
                r_left <= r_left + r_pw;
            end
        end
        if (w_load_err) begin
            r_out <= w_err_cell;
        end else if (w_load_cell) begin
            r_out <= w_cell;
        end
    end

    assign o_data  = r_out;
    assign o_valid = r_out_valid;

endmodule

/* design/torus_grid_partitioner_core.sv */
`timescale 1ns / 1ps

// Splits the configured area into a near-square torus grid of N cells and
// emits one result per cell in row-major order, followed by nothing else; a
// request with a zero cell count yields a single error result. A request is
// queued, and the back end then runs three divisions in turn on a shared
// one-bit-per-cycle divider (agent share, cell width, cell height), each
// iterating once per quotient bit before it hands over its result. The
// results then follow one per cycle while the output is not stalled, the
// first once the third division is done. A two-entry queue lets the next
// request be taken while one is emitted.
// Configuration writes are always accepted and must only occur while idle.
module torus_grid_partitioner_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  tgp_pkg::t_in                i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output tgp_pkg::t_out               o_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [tgp_pkg::ITEM_W-1:0]  i_cfg_data
);
    import tgp_pkg::*;

    logic [ITEM_W-1:0] r_area_width;
    logic [ITEM_W-1:0] r_area_height;
    logic [ID_W-1:0]   r_id_base;

    logic w_push;
    t_job w_push_job;
    logic w_full;
    logic w_pop;
    t_job w_head;
    logic w_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_width  <= 12'd1920;
            r_area_height <= 12'd1080;
            r_id_base     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AREA_WIDTH:  r_area_width  <= i_cfg_data;
                CFG_AREA_HEIGHT: r_area_height <= i_cfg_data;
                CFG_ID_BASE:     r_id_base     <= i_cfg_data[ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tgp_front u_front (
        .i_data  (i_data),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    tgp_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_job),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_data      (w_head),
        .o_empty     (w_empty)
    );

    tgp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (w_head),
        .i_job_empty   (w_empty),
        .o_job_pop     (w_pop),
        .i_area_width  (r_area_width),
        .i_area_height (r_area_height),
        .i_id_base     (r_id_base),
        .o_data        (o_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready)
    );

endmodule
